### hdl/hcs_pkg.sv
// Shared types and constants for the histogram contrast stretch block.
`timescale 1ns / 1ps
package hcs_pkg;

  localparam int unsigned BIN_COUNT  = 256;
  localparam int unsigned BIN_W      = $clog2(BIN_COUNT);
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned LEVEL_W    = 9;
  localparam int unsigned PIXEL_W    = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // input kind and result kind codes
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_MAP   = 1'b1;
  localparam logic RES_REPORT = 1'b0;
  localparam logic RES_PIXEL  = 1'b1;

  // bound values
  localparam logic [LEVEL_W-1:0] LOW_RESET  = 9'd0;
  localparam logic [LEVEL_W-1:0] HIGH_RESET = 9'd255;
  localparam logic [LEVEL_W-1:0] LOW_NONE   = 9'd256;
  localparam logic [LEVEL_W-1:0] HIGH_NONE  = 9'h1FF;

  localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 8'd255;
  localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 8'd0;

  // configuration register word index
  localparam logic REG_MIN_COUNT = 1'b0;

  typedef struct packed {
    logic               valid;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } pix_req_t;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [PIXEL_W-1:0] mapped;
    logic [LEVEL_W-1:0] low;
    logic [LEVEL_W-1:0] high;
  } result_t;

endpackage

### hdl/hcs_hist.sv
// Histogram memory: read-modify-write counting, bin scan and bound registers.
`timescale 1ns / 1ps
module hcs_hist (
  input  logic                          clk,
  input  logic                          rst,
  input  hcs_pkg::pix_req_t             req,
  input  logic [hcs_pkg::COUNT_W-1:0]   min_count,
  input  logic                          take,
  output logic                          ready,
  output hcs_pkg::result_t              res,
  output logic [hcs_pkg::LEVEL_W-1:0]   low_level,
  output logic [hcs_pkg::LEVEL_W-1:0]   high_level
);
  import hcs_pkg::*;

  typedef enum logic [1:0] {H_IDLE, H_SCAN, H_REPORT} hstate_t;

  hstate_t              state;
  logic [COUNT_W-1:0]   mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] bin_vld;

  logic [COUNT_W-1:0]   rd_data;
  logic                 rd_vld;
  logic [BIN_W-1:0]     rd_addr;

  // update stage
  logic                 s2_valid;
  logic [BIN_W-1:0]     s2_addr;
  logic                 s2_last;
  logic                 wr_fresh;
  logic [BIN_W-1:0]     wr_addr;
  logic [COUNT_W-1:0]   wr_data;
  logic [COUNT_W-1:0]   cnt_old;
  logic [COUNT_W-1:0]   cnt_new;

  // scan
  logic [BIN_W:0]       scan_cnt;
  logic                 chk_valid;
  logic [BIN_W-1:0]     chk_idx;
  logic [COUNT_W-1:0]   chk_cnt;
  logic                 hit;
  logic                 found;
  logic                 found_next;
  logic [BIN_W-1:0]     lo_acc;
  logic [BIN_W-1:0]     lo_acc_next;
  logic [BIN_W-1:0]     hi_acc;
  logic [BIN_W-1:0]     hi_acc_next;
  logic                 scan_done;

  assign rd_addr = (state == H_SCAN) ? scan_cnt[BIN_W-1:0] : req.pixel;

  // forward the write made at the same edge as this read
  always_comb begin
    if (wr_fresh && (wr_addr == s2_addr)) begin
      cnt_old = wr_data;
    end else if (rd_vld) begin
      cnt_old = rd_data;
    end else begin
      cnt_old = '0;
    end
    cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 1'b1;
  end

  always_comb begin
    chk_cnt     = rd_vld ? rd_data : '0;
    hit         = chk_valid && (chk_cnt > min_count);
    found_next  = found | hit;
    lo_acc_next = (hit && !found) ? chk_idx : lo_acc;
    hi_acc_next = hit ? chk_idx : hi_acc;
    scan_done   = chk_valid && (chk_idx == BIN_W'(BIN_COUNT - 1));
  end

  assign ready = (state == H_IDLE) && !(s2_valid && s2_last);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (s2_valid) begin
      mem[s2_addr] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr  <= req.pixel;
    s2_last  <= req.last;
    wr_addr  <= s2_addr;
    wr_data  <= cnt_new;
    chk_idx  <= scan_cnt[BIN_W-1:0];
    lo_acc   <= lo_acc_next;
    hi_acc   <= hi_acc_next;
    res.kind   <= RES_REPORT;
    res.mapped <= PIXEL_BLACK;
    if (rst) begin
      state      <= H_IDLE;
      bin_vld    <= '0;
      rd_vld     <= 1'b0;
      s2_valid   <= 1'b0;
      wr_fresh   <= 1'b0;
      scan_cnt   <= '0;
      chk_valid  <= 1'b0;
      found      <= 1'b0;
      res.valid  <= 1'b0;
      low_level  <= LOW_RESET;
      high_level <= HIGH_RESET;
    end else begin
      rd_vld    <= bin_vld[rd_addr];
      s2_valid  <= req.valid;
      wr_fresh  <= s2_valid;
      chk_valid <= (state == H_SCAN) && !scan_cnt[BIN_W];
      if (s2_valid) begin
        bin_vld[s2_addr] <= 1'b1;
      end
      case (state)
        H_IDLE: begin
          if (s2_valid && s2_last) begin
            state    <= H_SCAN;
            scan_cnt <= '0;
            found    <= 1'b0;
          end
        end
        H_SCAN: begin
          found <= found_next;
          if (!scan_cnt[BIN_W]) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (scan_done) begin
            bin_vld    <= '0;
            low_level  <= found_next ? {1'b0, lo_acc_next} : LOW_NONE;
            high_level <= found_next ? {1'b0, hi_acc_next} : HIGH_NONE;
            res.low    <= found_next ? {1'b0, lo_acc_next} : LOW_NONE;
            res.high   <= found_next ? {1'b0, hi_acc_next} : HIGH_NONE;
            res.valid  <= 1'b1;
            state      <= H_REPORT;
          end
        end
        H_REPORT: begin
          if (take) begin
            res.valid <= 1'b0;
            state     <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule

### hdl/hcs_map.sv
// Stretch mapping unit with a bit-per-cycle restoring divider.
`timescale 1ns / 1ps
module hcs_map (
  input  logic                          clk,
  input  logic                          rst,
  input  hcs_pkg::pix_req_t             req,
  input  logic [hcs_pkg::LEVEL_W-1:0]   low_level,
  input  logic [hcs_pkg::LEVEL_W-1:0]   high_level,
  input  logic                          take,
  output logic                          ready,
  output hcs_pkg::result_t              res
);
  import hcs_pkg::*;

  localparam int unsigned NUM_W = 17;

  typedef enum logic [1:0] {M_IDLE, M_PREP, M_DIV, M_DONE} mstate_t;

  mstate_t            state;
  logic [PIXEL_W-1:0] pix;
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   den_sh;
  logic [PIXEL_W-1:0] quo;
  logic [2:0]         step;

  logic signed [LEVEL_W:0] lo_s;
  logic signed [LEVEL_W:0] hi_s;
  logic signed [LEVEL_W:0] v_s;
  logic [PIXEL_W-1:0]      diff;
  logic [PIXEL_W-1:0]      span;
  logic [NUM_W-1:0]        num;
  logic                    go_div;
  logic [PIXEL_W-1:0]      fixed_out;
  logic                    fits;
  logic [NUM_W-1:0]        rem_sub;

  always_comb begin
    lo_s = signed'({1'b0, low_level});
    hi_s = signed'({high_level[LEVEL_W-1], high_level});
    v_s  = signed'({2'b00, pix});
    diff = pix - low_level[PIXEL_W-1:0];
    span = high_level[PIXEL_W-1:0] - low_level[PIXEL_W-1:0];
    // 510*diff + d, round half up once divided by 2d
    num  = NUM_W'(diff) * NUM_W'(510) + NUM_W'(span);
    go_div    = 1'b0;
    fixed_out = PIXEL_BLACK;
    if (lo_s > hi_s || v_s < lo_s) begin
      fixed_out = PIXEL_BLACK;
    end else if (v_s > hi_s) begin
      fixed_out = PIXEL_WHITE;
    end else if (lo_s == hi_s) begin
      fixed_out = PIXEL_BLACK;
    end else begin
      go_div = 1'b1;
    end
  end

  assign fits    = rem >= den_sh;
  assign rem_sub = rem - den_sh;
  assign ready   = (state == M_IDLE);

  always_ff @(posedge clk) begin
    res.kind <= RES_PIXEL;
    res.low  <= low_level;
    res.high <= high_level;
    if (req.valid) begin
      pix <= req.pixel;
    end
    if (rst) begin
      state     <= M_IDLE;
      res.valid <= 1'b0;
    end else begin
      case (state)
        M_IDLE: begin
          if (req.valid) begin
            state <= M_PREP;
          end
        end
        M_PREP: begin
          rem    <= num;
          den_sh <= NUM_W'({span, 1'b0}) << 7;
          quo    <= '0;
          step   <= 3'd7;
          if (go_div) begin
            state <= M_DIV;
          end else begin
            res.mapped <= fixed_out;
            res.valid  <= 1'b1;
            state      <= M_DONE;
          end
        end
        M_DIV: begin
          if (fits) begin
            rem <= rem_sub;
          end
          quo    <= {quo[PIXEL_W-2:0], fits};
          den_sh <= den_sh >> 1;
          step   <= step - 1'b1;
          if (step == 3'd0) begin
            res.mapped <= {quo[PIXEL_W-2:0], fits};
            res.valid  <= 1'b1;
            state      <= M_DONE;
          end
        end
        M_DONE: begin
          if (take) begin
            res.valid <= 1'b0;
            state     <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

### hdl/histogram_contrast_stretch.sv
// Top level of the two-pass 8-bit histogram contrast stretch.
`timescale 1ns / 1ps
// Pixels come in twice. Requests with tuser = 0 count the pixel into a 256-bin
// histogram of 21-bit saturating counts; these go at one per cycle while neither unit
// is busy, since the histogram memory is read, incremented and written back in a
// two-stage path that forwards a count written in the cycle a new read of the same
// bin issues. The request with tlast = 1 ends the count pass: after its own update
// the bins are scanned one per cycle through the memory's single read port with
// tready low, the lowest and highest bins whose count exceeds min_count become
// the stretch bounds, a bounds report goes out with tuser = 0, and the histogram
// is cleared at once by per-bin valid bits. Requests with tuser = 1 map one pixel
// each through the stretch; a pixel between distinct bounds, inclusive, goes
// through the eight-step restoring divider, and any other pixel skips it. Each
// mapped result carries the bounds it used. After reset the bounds are 0 and 255
// (identity map); no qualifying bin gives bounds 256 and -1 and maps every pixel
// to 0.
module histogram_contrast_stretch (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] kind
  input  logic        s_axis_tlast,   // last pixel of count pass
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] mapped_pixel, [16:8] low_bound,
                                      // [25:17] high_bound, [31:26] zero
  output logic        m_axis_tuser    // [0] result_kind
);
  import hcs_pkg::*;

  logic [COUNT_W-1:0] min_count;
  logic               cfg_wr;
  logic               in_acc;
  logic               hist_ready;
  logic               map_ready;
  pix_req_t           hist_req;
  pix_req_t           map_req;
  result_t            hist_res;
  result_t            map_res;
  result_t            pend;
  logic               out_load;
  logic [LEVEL_W-1:0] low_level;
  logic [LEVEL_W-1:0] high_level;

  // configuration port, word address in paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MIN_COUNT) ? 32'(min_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_count <= '0;
    end else if (cfg_wr && paddr[2] == REG_MIN_COUNT) begin
      min_count <= pwdata[COUNT_W-1:0];
    end
  end

  // one request at a time except for back-to-back count pixels
  assign s_axis_tready = hist_ready && map_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    hist_req.valid = in_acc && (s_axis_tuser == KIND_COUNT);
    hist_req.pixel = s_axis_tdata;
    hist_req.last  = s_axis_tlast;
    map_req.valid  = in_acc && (s_axis_tuser == KIND_MAP);
    map_req.pixel  = s_axis_tdata;
    map_req.last   = 1'b0;
  end

  hcs_hist u_hist (
    .clk        (clk),
    .rst        (rst),
    .req        (hist_req),
    .min_count  (min_count),
    .take       (out_load && hist_res.valid),
    .ready      (hist_ready),
    .res        (hist_res),
    .low_level  (low_level),
    .high_level (high_level)
  );

  hcs_map u_map (
    .clk        (clk),
    .rst        (rst),
    .req        (map_req),
    .low_level  (low_level),
    .high_level (high_level),
    .take       (out_load && map_res.valid),
    .ready      (map_ready),
    .res        (map_res)
  );

  // output register; at most one unit holds a finished result
  assign pend     = hist_res.valid ? hist_res : map_res;
  assign out_load = pend.valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, pend.high, pend.low, pend.mapped};
      m_axis_tuser <= pend.kind;
    end
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  a_one_pending: assert property (@(posedge clk) disable iff (rst)
    !(hist_res.valid && map_res.valid))
    else $error("both units hold a result");

  a_scan_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == KIND_COUNT && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken during bin scan");

  a_report_black: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == RES_REPORT) |-> (m_axis_tdata[7:0] == PIXEL_BLACK))
    else $error("bounds report with nonzero pixel");

  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    map_req.valid |=> !s_axis_tready)
    else $error("input taken while mapping");

endmodule

### bench/histogram_contrast_stretch_tb.sv
// Self-checking testbench for the two-pass histogram contrast stretch block.
`timescale 1ns / 1ps
// Method: the bench starts with a table of directed requests. Some rows carry a
// typed-in expected result, and others are checked through the bench's own
// stretch predictor. Six random phases follow. Each phase sets its own
// min_count and its own sender and receiver idle rates. Most random traffic is
// whole frames: a count pass over a random grey band that ends in tlast, then
// a map pass. The rest is loose requests of any kind. The predictor runs on
// every accepted request and queues the result it expects. Every result that
// comes out is compared field by field with the oldest queued result.
module histogram_contrast_stretch_tb;
  import hcs_pkg::*;

  // Slowest correct run: about 1600 requests plus about 100 bin scans, all stretched
  // by 67% stalls, so this limit is generous.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int QUIET_CYCLES   = 24;   // count update path is two stages deep
  localparam int TAIL_CYCLES    = 400;  // longer than one full bin scan
  localparam int PHASE_REQUESTS = 240;
  localparam int PHASES         = 6;
  localparam int REPORT_LIMIT   = 10;

  // register byte addresses: word index times four
  localparam logic [2:0]  ADDR_MIN_COUNT = 3'(4 * REG_MIN_COUNT);
  localparam logic [2:0]  ADDR_SPARE     = 3'd4;  // no register here, writes dropped
  localparam logic [20:0] FLOOR_MAX      = 21'd1048576;

  // one expected result, with the fields of m_axis
  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] mapped;
    logic [LEVEL_W-1:0] lo_b;
    logic [LEVEL_W-1:0] hi_b;
  } stretch_res_t;

  // Goes with each request. When pinned is set, the typed-in result stands
  // in for the predictor's result.
  typedef struct packed {
    logic         pinned;
    stretch_res_t res;
  } request_hint_t;

  typedef enum logic {OP_PIXEL, OP_WRITE} plan_op_t;

  typedef struct packed {
    plan_op_t           op;
    logic [2:0]         addr;
    logic [20:0]        wval;
    logic               kind;
    logic [PIXEL_W-1:0] pix;
    logic               last;
    logic               pinned;
    stretch_res_t       res;
  } plan_row_t;

  localparam int ROWS = 28;

  // Directed table. Columns: op, addr, value, kind, pixel, last, pinned, then
  // the pinned result (kind, mapped, low, high).
  localparam plan_row_t PLAN [ROWS] = '{
    // after reset the bounds are 0 and 255, so the map is the identity
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd0,   1'b0, 1'b1,
      '{RES_PIXEL, 8'd0, 9'd0, 9'd255}},
    // tlast on a map request is ignored
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd255, 1'b1, 1'b1,
      '{RES_PIXEL, 8'd255, 9'd0, 9'd255}},
    // one occupied level: equal bounds
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd100, 1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd100, 1'b1, 1'b1,
      '{RES_REPORT, 8'd0, 9'd100, 9'd100}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd99,  1'b0, 1'b1,
      '{RES_PIXEL, 8'd0, 9'd100, 9'd100}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd100, 1'b0, 1'b1,
      '{RES_PIXEL, 8'd0, 9'd100, 9'd100}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd101, 1'b0, 1'b1,
      '{RES_PIXEL, 8'd255, 9'd100, 9'd100}},
    // full range bounds
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd0,   1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd255, 1'b1, 1'b1,
      '{RES_REPORT, 8'd0, 9'd0, 9'd255}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd64,  1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd170, 1'b0, 1'b0, '0},
    // bounds 3 and 200, pixels just outside both ends
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd3,   1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd200, 1'b1, 1'b1,
      '{RES_REPORT, 8'd0, 9'd3, 9'd200}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd2,   1'b0, 1'b1,
      '{RES_PIXEL, 8'd0, 9'd3, 9'd200}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd201, 1'b0, 1'b1,
      '{RES_PIXEL, 8'd255, 9'd3, 9'd200}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd101, 1'b0, 1'b0, '0},
    // min_count 1: single hits no longer count
    '{OP_WRITE, ADDR_MIN_COUNT, 21'd1, 1'b0, 8'd0, 1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd50,  1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd50,  1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd60,  1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd70,  1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd70,  1'b1, 1'b1,
      '{RES_REPORT, 8'd0, 9'd50, 9'd70}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd60,  1'b0, 1'b0, '0},
    // A write past the last register must be dropped. min_count stays 1, so
    // the single hit below leaves no bin qualifying.
    '{OP_WRITE, ADDR_SPARE, 21'd0, 1'b0, 8'd0, 1'b0, 1'b0, '0},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_COUNT, 8'd5,   1'b1, 1'b1,
      '{RES_REPORT, 8'd0, LOW_NONE, HIGH_NONE}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd0,   1'b0, 1'b1,
      '{RES_PIXEL, 8'd0, LOW_NONE, HIGH_NONE}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd255, 1'b0, 1'b1,
      '{RES_PIXEL, 8'd0, LOW_NONE, HIGH_NONE}},
    '{OP_PIXEL, 3'd0, 21'd0, KIND_MAP,   8'd128, 1'b1, 1'b0, '0}
  };

  localparam int GAP_PCT   [PHASES] = '{0, 67, 0, 38, 0, 38};
  localparam int STALL_PCT [PHASES] = '{0, 0, 67, 38, 0, 38};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] pixel
  logic        s_axis_tuser;   // [0] kind
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;   // [7:0] mapped, [16:8] low, [25:17] high, [31:26] zero
  logic        m_axis_tuser;   // [0] result kind

  histogram_contrast_stretch i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state: the bench's own copy of the block
  logic [COUNT_W-1:0] bin_tally [BIN_COUNT];
  logic [COUNT_W-1:0] count_floor;
  logic [LEVEL_W-1:0] low_lvl;
  logic [LEVEL_W-1:0] high_lvl;   // two's complement, 0x1FF when no bin qualifies

  request_hint_t hint_q [$];      // one per request sent, popped on accept
  stretch_res_t  awaited_q [$];   // expected results, oldest first

  int gap_pct;
  int stall_pct;
  int faults;
  int requests_sent;
  int reports_seen;
  int pixels_seen;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Map one level through the stored bounds. Rounding is half up.
  function automatic logic [PIXEL_W-1:0] stretch_level(logic [PIXEL_W-1:0] p);
    int lo, hi, v, d;
    lo = int'(low_lvl);
    hi = int'($signed(high_lvl));
    v  = int'(p);
    if (lo > hi || v < lo) return PIXEL_BLACK;
    if (v > hi) return PIXEL_WHITE;
    if (lo == hi) return PIXEL_BLACK;   // equal bounds: the level itself maps to 0
    d = hi - lo;
    return 8'((510 * (v - lo) + d) / (2 * d));
  endfunction

  // Advance the predictor by one request. Returns 1 when it makes a result.
  function automatic bit stretch_step(logic kind, logic [PIXEL_W-1:0] pix, logic last,
                                      output stretch_res_t res);
    int lo, hi, i;
    res = '0;
    if (kind == KIND_COUNT) begin
      if (bin_tally[pix] != COUNT_MAX) bin_tally[pix] = bin_tally[pix] + 1'b1;
      if (!last) return 1'b0;
      lo = BIN_COUNT;
      hi = -1;
      for (i = 0; i < BIN_COUNT; i++) begin
        if (bin_tally[i] > count_floor) begin
          if (lo == BIN_COUNT) lo = i;
          hi = i;
        end
      end
      low_lvl  = lo[LEVEL_W-1:0];
      high_lvl = hi[LEVEL_W-1:0];
      for (i = 0; i < BIN_COUNT; i++) bin_tally[i] = '0;
      res.kind   = RES_REPORT;
      res.mapped = PIXEL_BLACK;
    end else begin
      res.kind   = RES_PIXEL;
      res.mapped = stretch_level(pix);
    end
    res.lo_b = low_lvl;
    res.hi_b = high_lvl;
    return 1'b1;
  endfunction

  // Receiver: stall at the rate the current phase asks for.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Scoreboard. Register writes and accepted requests feed the predictor.
  // Accepted results are checked against the oldest expectation.
  stretch_res_t  made;
  stretch_res_t  want;
  request_hint_t hint;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BIN_COUNT; i++) bin_tally[i] = '0;
      count_floor = '0;
      low_lvl     = LOW_RESET;
      high_lvl    = HIGH_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_MIN_COUNT)
        count_floor = pwdata[COUNT_W-1:0];

      if (s_axis_tvalid && s_axis_tready) begin
        hint = hint_q.pop_front();
        if (stretch_step(s_axis_tuser, s_axis_tdata, s_axis_tlast, made))
          awaited_q.push_back(hint.pinned ? hint.res : made);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tuser == RES_REPORT) reports_seen++;
        else pixels_seen++;
        if (awaited_q.size() == 0) begin
          if (faults < REPORT_LIMIT)
            $display("%0t: result with nothing expected: kind %0d data %h",
                     $realtime, m_axis_tuser, m_axis_tdata);
          faults++;
        end else begin
          want = awaited_q.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.mapped ||
              m_axis_tdata[16:8] !== want.lo_b || m_axis_tdata[25:17] !== want.hi_b ||
              m_axis_tdata[31:26] !== 6'd0) begin
            if (faults < REPORT_LIMIT)
              $display({"%0t: mismatch exp/got: kind %0d/%0d mapped %0d/%0d ",
                        "low %0d/%0d high %0d/%0d pad 0/%0d"}, $realtime,
                       want.kind, m_axis_tuser, want.mapped, m_axis_tdata[7:0],
                       want.lo_b, m_axis_tdata[16:8], $signed(want.hi_b),
                       $signed(m_axis_tdata[25:17]), m_axis_tdata[31:26]);
            faults++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, awaited_q.size());
      $display("histogram_contrast_stretch_tb: done, errors");
      $finish;
    end
  end

  // Send one pixel request after a random idle gap, and hold it until accepted.
  task automatic send_pixel(logic kind, logic [PIXEL_W-1:0] pix, logic last,
                            logic pinned, stretch_res_t res);
    hint_q.push_back('{pinned, res});
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= pix;
    s_axis_tlast  <= last;
    requests_sent++;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Wait until every expected result is in, then hold quiet a while longer.
  task automatic wait_quiet(int extra);
    s_axis_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle. pready is always high.
  task automatic write_reg(logic [2:0] addr, logic [20:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int phase, row, k, n, m, sent, lo_pix, hi_pix;
    logic [20:0] floor_val;
    logic [7:0]  pix;

    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_COUNT;
    s_axis_tlast  <= 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    faults        = 0;
    requests_sent = 0;
    reports_seen  = 0;
    pixels_seen   = 0;
    cycles        = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, run with no idling
    for (row = 0; row < ROWS; row++) begin
      if (PLAN[row].op == OP_WRITE) begin
        wait_quiet(QUIET_CYCLES);
        write_reg(PLAN[row].addr, PLAN[row].wval);
      end else begin
        send_pixel(PLAN[row].kind, PLAN[row].pix, PLAN[row].last,
                   PLAN[row].pinned, PLAN[row].res);
      end
    end

    // random phases, each with its own threshold and idle rates
    for (phase = 0; phase < PHASES; phase++) begin
      wait_quiet(QUIET_CYCLES);
      case (phase)
        0:       floor_val = '0;
        1:       floor_val = 21'($urandom_range(3));
        2:       floor_val = 21'd1;
        3:       floor_val = FLOOR_MAX;   // nothing can qualify
        4:       floor_val = 21'($urandom_range(FLOOR_MAX));
        default: floor_val = 21'd2;
      endcase
      write_reg(ADDR_MIN_COUNT, floor_val);
      gap_pct   = GAP_PCT[phase];
      stall_pct = STALL_PCT[phase];

      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        if ($urandom_range(99) < 82) begin
          // Whole frame. Counts cluster in a random band with some strays,
          // and the map pass mixes in-band and arbitrary levels.
          lo_pix = $urandom_range(255);
          hi_pix = $urandom_range(255, lo_pix);
          n = $urandom_range(40, 1);
          for (k = 0; k < n; k++) begin
            pix = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(hi_pix, lo_pix));
            send_pixel(KIND_COUNT, pix, k == n - 1, 1'b0, '0);
          end
          m = $urandom_range(24, 1);
          for (k = 0; k < m; k++) begin
            pix = $urandom_range(1) ? 8'($urandom_range(255))
                                    : 8'($urandom_range(hi_pix, lo_pix));
            send_pixel(KIND_MAP, pix, $urandom_range(9) == 0, 1'b0, '0);
          end
          sent += n + m;
        end else begin
          // loose requests of any kind, an occasional stray tlast
          n = $urandom_range(6, 1);
          for (k = 0; k < n; k++)
            send_pixel(1'($urandom_range(1)), 8'($urandom_range(255)),
                       $urandom_range(7) == 0, 1'b0, '0);
          sent += n;
        end
      end
    end

    wait_quiet(TAIL_CYCLES);
    if (awaited_q.size() != 0) begin
      $display("%0d expected results never arrived", awaited_q.size());
      faults += awaited_q.size();
    end

    $display("%0d pixel requests over a directed table and %0d random phases",
             requests_sent, PHASES);
    $display("checked %0d bound reports and %0d mapped pixels, %0d failures",
             reports_seen, pixels_seen, faults);
    if (faults == 0) begin
      $display("histogram_contrast_stretch_tb: done, clean");
    end else begin
      $display("histogram_contrast_stretch_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/hcs_pkg.sv
hdl/hcs_hist.sv
hdl/hcs_map.sv
hdl/histogram_contrast_stretch.sv
bench/histogram_contrast_stretch_tb.sv
